>>> hdl/assert_macros.svh
// Assertion macros used by the scheduler top level.
// Defining ASSERT_OFF turns every macro into an empty body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: lbl");

// Condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition: lbl");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> hdl/plts_pkg.sv
// Package for the preemptive LIFO task scheduler: widths, types, FSM codes.
// No dependencies.
`timescale 1ns / 1ps

package plts_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int MIN_PER_HOUR    = 60;

    localparam int ID_W    = 16;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int DUR_W   = 10;
    // Start time in minutes: at most 31 * 60 + 63 = 1923
    localparam int START_W = 11;

    // One paused task in the stack memory
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [DUR_W-1:0] rem;
    } t_entry;

    // Result handed from the sequencer to the output register
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
        logic            eor;
        logic            ovf;
    } t_res_push;

    // Sequencer status seen by the top level
    typedef struct packed {
        logic pend_v;
        logic ovf;
    } t_core_status;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_POP   = 5'b00010,
        S_FIN   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

endpackage

>>> hdl/plts_if.sv
// Valid/ready channel interfaces for task arrivals and completions.
// Depends on plts_pkg.
`timescale 1ns / 1ps

interface plts_task_if import plts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   task_id;
    logic [HOUR_W-1:0] start_hour;
    logic [MIN_W-1:0]  start_minute;
    logic [DUR_W-1:0]  duration;
    logic              final_task;

    modport source (output valid, task_id, start_hour, start_minute, duration,
                    final_task, input ready);
    modport sink   (input valid, task_id, start_hour, start_minute, duration,
                    final_task, output ready);
endinterface

interface plts_done_if import plts_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] finished_id;
    logic            end_of_run;
    logic            stack_overflow;

    modport source (output valid, finished_id, end_of_run, stack_overflow, input ready);
    modport sink   (input valid, finished_id, end_of_run, stack_overflow, output ready);
endinterface

>>> hdl/plts_stack_mem.sv
// Paused-task stack storage: one write port, one read port, registered read.
// Depends on plts_pkg.
`timescale 1ns / 1ps

module plts_stack_mem import plts_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int ADDR_W     = $clog2(STACK_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_entry            i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_entry            o_rd_data
);

    t_entry r_mem [STACK_DEPTH];
    t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/plts_core.sv
// Scheduler sequencer: running-task registers, clock, stack pointer, pop/drain FSM.
// Depends on plts_pkg, plts_if (task channel) and drives plts_stack_mem.
`timescale 1ns / 1ps

module plts_core import plts_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int ADDR_W     = $clog2(STACK_DEPTH),
    localparam int CNT_W      = $clog2(STACK_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    plts_task_if.sink         i_task,
    input  logic              i_out_free,
    output t_res_push         o_push,
    output t_core_status      o_status,
    output logic              o_wr_en,
    output logic [ADDR_W-1:0] o_wr_addr,
    output t_entry            o_wr_data,
    output logic              o_rd_en,
    output logic [ADDR_W-1:0] o_rd_addr,
    input  t_entry            i_rd_data
);

    t_state               r_state, n_state;
    logic                 r_have, n_have;
    logic [ID_W-1:0]      r_cur_id, n_cur_id;
    logic [DUR_W-1:0]     r_cur_rem, n_cur_rem;
    logic [START_W-1:0]   r_clk, n_clk;
    logic [START_W-1:0]   r_start, n_start;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_ovf, n_ovf;
    logic                 r_pend_v, n_pend_v;
    logic [ID_W-1:0]      r_pend_id, n_pend_id;
    logic [ID_W-1:0]      r_new_id, n_new_id;
    logic [DUR_W-1:0]     r_new_dur, n_new_dur;
    logic                 r_fin, n_fin;

    logic                 accept;
    logic [START_W-1:0]   start_raw;
    logic [START_W-1:0]   start_eff;
    logic [START_W:0]     cur_end;
    logic [START_W:0]     top_end;
    logic [START_W-1:0]   arr_gap;
    logic [START_W-1:0]   pop_gap;
    logic [ADDR_W-1:0]    top_addr;
    logic [ADDR_W-1:0]    next_addr;

    assign accept = i_task.valid && i_task.ready;

    // arrival time in minutes, clamped to the clock while a task runs
    assign start_raw = START_W'(i_task.start_hour) * START_W'(MIN_PER_HOUR)
                     + START_W'(i_task.start_minute);
    assign start_eff = (r_have && (start_raw < r_clk)) ? r_clk : start_raw;
    assign arr_gap   = start_eff - r_clk;
    assign cur_end   = {1'b0, r_clk} + (START_W + 1)'(r_cur_rem);

    // stack top as seen in the pop loop
    assign top_end   = {1'b0, r_clk} + (START_W + 1)'(i_rd_data.rem);
    assign pop_gap   = r_start - r_clk;
    assign top_addr  = ADDR_W'(r_cnt - CNT_W'(1));
    assign next_addr = ADDR_W'(r_cnt - CNT_W'(2));

    // no transaction is taken while reset is held
    assign i_task.ready = i_rst_n && (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_have    = r_have;
        n_cur_id  = r_cur_id;
        n_cur_rem = r_cur_rem;
        n_clk     = r_clk;
        n_start   = r_start;
        n_cnt     = r_cnt;
        n_ovf     = r_ovf;
        n_pend_v  = r_pend_v;
        n_pend_id = r_pend_id;
        n_new_id  = r_new_id;
        n_new_dur = r_new_dur;
        n_fin     = r_fin;
        o_push    = '0;
        o_wr_en   = 1'b0;
        o_wr_addr = top_addr;
        o_wr_data = '0;
        o_rd_en   = 1'b0;
        o_rd_addr = top_addr;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_new_id  = i_task.task_id;
                    n_new_dur = i_task.duration;
                    n_fin     = i_task.final_task;
                    n_start   = start_eff;
                    if (!r_have || (cur_end > {1'b0, start_eff})) begin
                        // preempt the running task (if any)
                        if (r_have) begin
                            if (r_cnt < CNT_W'(STACK_DEPTH)) begin
                                o_wr_en       = 1'b1;
                                o_wr_addr     = ADDR_W'(r_cnt);
                                o_wr_data.id  = r_cur_id;
                                o_wr_data.rem = DUR_W'({1'b0, r_cur_rem} - arr_gap);
                                n_cnt         = r_cnt + CNT_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        n_have    = 1'b1;
                        n_cur_id  = i_task.task_id;
                        n_cur_rem = i_task.duration;
                        n_clk     = start_eff;
                        n_state   = i_task.final_task ? S_FIN : S_IDLE;
                    end else begin
                        // running task completes before the arrival
                        n_pend_v  = 1'b1;
                        n_pend_id = r_cur_id;
                        n_clk     = cur_end[START_W-1:0];
                        if (r_cnt != '0) begin
                            o_rd_en = 1'b1;
                            n_state = S_POP;
                        end else begin
                            n_cur_id  = i_task.task_id;
                            n_cur_rem = i_task.duration;
                            n_clk     = start_eff;
                            n_state   = i_task.final_task ? S_FIN : S_FLUSH;
                        end
                    end
                end
            end

            S_POP: begin
                if (top_end <= {1'b0, r_start}) begin
                    // top finishes in the gap: emit and pop
                    if (i_out_free) begin
                        o_push.valid = 1'b1;
                        o_push.id    = r_pend_id;
                        o_push.ovf   = r_ovf;
                        n_pend_id    = i_rd_data.id;
                        n_clk        = top_end[START_W-1:0];
                        n_cnt        = r_cnt - CNT_W'(1);
                        if (r_cnt != CNT_W'(1)) begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = next_addr;
                        end else begin
                            n_cur_id  = r_new_id;
                            n_cur_rem = r_new_dur;
                            n_clk     = r_start;
                            n_state   = r_fin ? S_FIN : S_FLUSH;
                        end
                    end else begin
                        o_rd_en = 1'b1;
                    end
                end else begin
                    // top resumes and is paused again at the arrival
                    o_wr_en       = 1'b1;
                    o_wr_data.id  = i_rd_data.id;
                    o_wr_data.rem = DUR_W'({1'b0, i_rd_data.rem} - pop_gap);
                    n_cur_id      = r_new_id;
                    n_cur_rem     = r_new_dur;
                    n_clk         = r_start;
                    n_state       = r_fin ? S_FIN : S_FLUSH;
                end
            end

            S_FIN: begin
                // the final task completes, then the run ends
                if (!r_pend_v || i_out_free) begin
                    o_push.valid = r_pend_v;
                    o_push.id    = r_pend_id;
                    o_push.ovf   = r_ovf;
                    n_pend_v     = 1'b1;
                    n_pend_id    = r_cur_id;
                    n_have       = 1'b0;
                    n_cur_id     = '0;
                    n_cur_rem    = '0;
                    n_clk        = '0;
                    if (r_cnt != '0) begin
                        o_rd_en = 1'b1;
                        n_state = S_DRAIN;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end

            S_DRAIN: begin
                if (i_out_free) begin
                    o_push.valid = 1'b1;
                    o_push.id    = r_pend_id;
                    o_push.ovf   = r_ovf;
                    n_pend_id    = i_rd_data.id;
                    n_cnt        = r_cnt - CNT_W'(1);
                    if (r_cnt != CNT_W'(1)) begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = next_addr;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end else begin
                    o_rd_en = 1'b1;
                end
            end

            S_FLUSH: begin
                // last completion of this transaction
                if (i_out_free) begin
                    o_push.valid = 1'b1;
                    o_push.id    = r_pend_id;
                    o_push.eor   = 1'b1;
                    o_push.ovf   = r_ovf;
                    n_pend_v     = 1'b0;
                    n_ovf        = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_have   <= 1'b0;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_have   <= n_have;
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
            r_pend_v <= n_pend_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_cur_id  <= n_cur_id;
        r_cur_rem <= n_cur_rem;
        r_clk     <= n_clk;
        r_start   <= n_start;
        r_pend_id <= n_pend_id;
        r_new_id  <= n_new_id;
        r_new_dur <= n_new_dur;
        r_fin     <= n_fin;
    end

    assign o_status.pend_v = r_pend_v;
    assign o_status.ovf    = r_ovf;

endmodule

>>> hdl/preemptive_lifo_task_scheduler_unit.sv
// Top level of the preemptive LIFO task scheduler: sequencer, stack memory, output register.
// Depends on plts_pkg, plts_if, plts_stack_mem, plts_core and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Tasks arrive in start-time order on i_task; an arrival preempts the running task unless
// that task ends by the arrival time, and the preempted task is pushed with its remaining
// minutes onto a LIFO stack of STACK_DEPTH entries in a single-port-write, registered-read
// memory. Completed task ids leave on o_done; the last completion caused by a transaction
// carries end_of_run, and stack_overflow marks every completion of the first transaction
// with results after a task was dropped on a full stack. An arrival that causes completions
// visits the pop state while stack entries remain, popping one entry per cycle while the
// output register is free, or pausing the resumed top again if it ends after the arrival;
// a final task then visits the final state and, while entries remain, the drain state; the
// flush state emits the last completion. The result register lets the next completion be
// formed while the previous one waits.
module preemptive_lifo_task_scheduler_unit import plts_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    plts_task_if.sink   i_task,
    plts_done_if.source o_done
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);

    t_res_push         core_push;
    t_core_status      core_status;
    logic              out_free;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_entry            wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    t_entry            rd_data;

    logic              r_out_v;
    logic [ID_W-1:0]   r_out_id;
    logic              r_out_eor;
    logic              r_out_ovf;

    plts_core #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_task     (i_task),
        .i_out_free (out_free),
        .o_push     (core_push),
        .o_status   (core_status),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    plts_stack_mem #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // output register: free when empty or being taken this cycle
    assign out_free = !r_out_v || o_done.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (core_push.valid && out_free) begin
            r_out_v <= 1'b1;
        end else if (o_done.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_push.valid && out_free) begin
            r_out_id  <= core_push.id;
            r_out_eor <= core_push.eor;
            r_out_ovf <= core_push.ovf;
        end
    end

    assign o_done.valid          = r_out_v;
    assign o_done.finished_id    = r_out_id;
    assign o_done.end_of_run     = r_out_eor;
    assign o_done.stack_overflow = r_out_ovf;

    // sequencer never overwrites a result that is still waiting
    `ASSERT_NEVER(a_push_when_full, i_clk, i_rst_n, core_push.valid && !out_free)
    // a new transaction starts with no completion pending
    `ASSERT_PROP(a_idle_no_pend, i_clk, i_rst_n, i_task.ready |-> !core_status.pend_v)
    // after the last completion the block takes a new task
    `ASSERT_PROP(a_eor_then_ready, i_clk, i_rst_n, (core_push.valid && core_push.eor) |=> i_task.ready)
    // a latched overflow marks every completion handed out
    `ASSERT_PROP(a_ovf_marks, i_clk, i_rst_n, (core_push.valid && core_status.ovf) |-> core_push.ovf)

endmodule
